// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define DICM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define DICM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/dicm_pkg.sv =====
// Shared types and constants of the digital input change mapper.
// No dependencies.
`default_nettype none

package dicm_pkg;

  localparam int unsigned PinW        = 16;  // pin word width
  localparam int unsigned PinIdxW     = 4;   // pin number width
  localparam int unsigned TgtW        = 8;   // target / slot width
  localparam int unsigned ValW        = 16;  // mapped value width
  localparam int unsigned CfgIdxW     = 2;   // config register index width
  localparam int unsigned DefPinCount = 16;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgEnable = 2'd0,
    CfgInvert = 2'd1,
    CfgSync   = 2'd2
  } cfg_idx_e;

  // Request kinds
  typedef enum logic {
    KindSample = 1'b0,
    KindLoad   = 1'b1
  } kind_e;

  typedef enum logic {
    StIdle = 1'b0,
    StScan = 1'b1
  } st_e;

  // One mapping table entry
  typedef struct packed {
    logic            active;
    logic [TgtW-1:0] target;
    logic [TgtW-1:0] slot;
    logic [ValW-1:0] fall;
    logic [ValW-1:0] rise;
  } map_entry_t;

endpackage

`default_nettype wire

// ===== design/dicm_map_table.sv =====
// Per-pin mapping table: active flags cleared at reset, payload held until written.
// Depends on dicm_pkg.
`default_nettype none

module dicm_map_table #(
  parameter int unsigned PIN_COUNT = dicm_pkg::DefPinCount,
  parameter int unsigned IdxW      = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 wr_en_i,
  input  wire logic [IdxW-1:0]      wr_idx_i,
  input  wire dicm_pkg::map_entry_t wr_entry_i,
  input  wire logic [IdxW-1:0]      rd_idx_i,
  output dicm_pkg::map_entry_t      rd_entry_o
);
  import dicm_pkg::*;

  logic [PIN_COUNT-1:0] active_q;
  logic [TgtW-1:0]      target_q [PIN_COUNT];
  logic [TgtW-1:0]      slot_q   [PIN_COUNT];
  logic [ValW-1:0]      fall_q   [PIN_COUNT];
  logic [ValW-1:0]      rise_q   [PIN_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (wr_en_i) begin
      active_q[wr_idx_i] <= wr_entry_i.active;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      target_q[wr_idx_i] <= wr_entry_i.target;
      slot_q[wr_idx_i]   <= wr_entry_i.slot;
      fall_q[wr_idx_i]   <= wr_entry_i.fall;
      rise_q[wr_idx_i]   <= wr_entry_i.rise;
    end
  end

  always_comb begin
    rd_entry_o.active = active_q[rd_idx_i];
    rd_entry_o.target = target_q[rd_idx_i];
    rd_entry_o.slot   = slot_q[rd_idx_i];
    rd_entry_o.fall   = fall_q[rd_idx_i];
    rd_entry_o.rise   = rise_q[rd_idx_i];
  end

endmodule

`default_nettype wire

// ===== design/digital_input_change_mapper_top.sv =====
// Digital input change mapper, top level: config registers, bit-serial scan, output register.
// Depends on dicm_pkg, dicm_map_table and assert_macros.svh.
// Flow: an accepted sample request starts a scan that steps through the pins up to the highest
// changed pin and ends once it sees no change left; output stalls hold the scan at a change.
// Each result is registered in the output register. A load request writes the table on acceptance.
// Reset (async, active low): levels, map active flags and config registers cleared.
`default_nettype none

module digital_input_change_mapper_top #(
  parameter int unsigned PIN_COUNT = dicm_pkg::DefPinCount
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // request channel
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            kind_i,
  input  wire logic [dicm_pkg::PinW-1:0]       pins_i,
  input  wire logic [dicm_pkg::PinIdxW-1:0]    entry_index_i,
  input  wire logic                            entry_active_i,
  input  wire logic [dicm_pkg::TgtW-1:0]       entry_target_i,
  input  wire logic [dicm_pkg::TgtW-1:0]       entry_target_slot_i,
  input  wire logic [dicm_pkg::ValW-1:0]       entry_fall_value_i,
  input  wire logic [dicm_pkg::ValW-1:0]       entry_rise_value_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [dicm_pkg::PinIdxW-1:0]         pin_index_o,
  output logic                                 level_o,
  output logic [dicm_pkg::PinW-1:0]            level_word_o,
  output logic                                 map_write_o,
  output logic [dicm_pkg::TgtW-1:0]            map_target_o,
  output logic [dicm_pkg::TgtW-1:0]            map_target_slot_o,
  output logic [dicm_pkg::ValW-1:0]            map_value_o,
  output logic                                 last_o,
  // configuration write channel
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [dicm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [dicm_pkg::PinW-1:0]       cfg_data_i
);
  import dicm_pkg::*;

  localparam int unsigned IdxW = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
  // Pins at or above PIN_COUNT are never watched
  localparam logic [PinW-1:0] PinMask = {PinW{1'b1}} >> (PinW - PIN_COUNT);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [PinW-1:0] enable_q, invert_q, sync_q;
  logic            cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
      invert_q <= '0;
      sync_q   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgEnable: enable_q <= cfg_data_i;
        CfgInvert: invert_q <= cfg_data_i;
        CfgSync:   sync_q   <= cfg_data_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Request acceptance
  // ---------------------------------------------------------------------------
  st_e  state_q, state_d;
  logic in_acc, smp_acc, load_acc;

  assign in_acc   = in_valid_i & ~in_stall_o;
  assign smp_acc  = in_acc & (kind_e'(kind_i) == KindSample);
  assign load_acc = in_acc & (kind_e'(kind_i) == KindLoad);

  // ---------------------------------------------------------------------------
  // Mapping table; out-of-range load index is dropped
  // ---------------------------------------------------------------------------
  map_entry_t wr_entry, rd_entry;
  logic       tbl_wr;
  logic [PinIdxW-1:0] cnt_q, cnt_d;

  assign tbl_wr = load_acc & ({1'b0, entry_index_i} < (PinIdxW + 1)'(PIN_COUNT));

  always_comb begin
    wr_entry.active = entry_active_i;
    wr_entry.target = entry_target_i;
    wr_entry.slot   = entry_target_slot_i;
    wr_entry.fall   = entry_fall_value_i;
    wr_entry.rise   = entry_rise_value_i;
  end

  dicm_map_table #(
    .PIN_COUNT (PIN_COUNT),
    .IdxW      (IdxW)
  ) u_map_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (tbl_wr),
    .wr_idx_i   (entry_index_i[IdxW-1:0]),
    .wr_entry_i (wr_entry),
    .rd_idx_i   (cnt_q[IdxW-1:0]),
    .rd_entry_o (rd_entry)
  );

  // ---------------------------------------------------------------------------
  // Bit-serial scan: change, level and sync bits shift out LSB first,
  // cnt_q tracks which pin sits at bit 0. Scan ends once no change remains.
  // ---------------------------------------------------------------------------
  logic [PinW-1:0] chg_sr_q, chg_sr_d;
  logic [PinW-1:0] lvl_sr_q, lvl_sr_d;
  logic [PinW-1:0] syn_sr_q, syn_sr_d;
  logic [PinW-1:0] stored_q, stored_d;
  logic [PinW-1:0] qual;
  logic            scanning, out_free, evt, step, emit;
  logic            wr_map, lvl;
  logic [PinW-1:0] word_new;

  assign qual     = pins_i ^ invert_q;
  assign out_free = ~out_valid_o | ~out_stall_i;
  assign evt      = scanning & chg_sr_q[0];
  assign step     = scanning & (~chg_sr_q[0] | out_free);
  assign emit     = evt & out_free;
  assign lvl      = lvl_sr_q[0];
  // active entries: falling write always, rising write unless held off by sync
  assign wr_map   = rd_entry.active & (~lvl | ~syn_sr_q[0]);

  always_comb begin
    word_new        = stored_q;
    word_new[cnt_q] = lvl;
  end

  always_comb begin
    chg_sr_d = chg_sr_q;
    lvl_sr_d = lvl_sr_q;
    syn_sr_d = syn_sr_q;
    cnt_d    = cnt_q;
    stored_d = stored_q;
    if (smp_acc) begin
      chg_sr_d = (qual ^ stored_q) & enable_q & PinMask;
      lvl_sr_d = qual;
      syn_sr_d = sync_q;
      cnt_d    = '0;
    end else if (step) begin
      chg_sr_d = chg_sr_q >> 1;
      lvl_sr_d = lvl_sr_q >> 1;
      syn_sr_d = syn_sr_q >> 1;
      cnt_d    = cnt_q + PinIdxW'(1);
      if (evt) begin
        stored_d = word_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q <= '0;
      chg_sr_q <= '0;
      cnt_q    <= '0;
    end else begin
      stored_q <= stored_d;
      chg_sr_q <= chg_sr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_sr_q <= lvl_sr_d;
    syn_sr_q <= syn_sr_d;
  end

  // ---------------------------------------------------------------------------
  // Scan control
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (smp_acc) state_d = StScan;
      StScan: if (chg_sr_q == '0) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    scanning   = 1'b0;
    in_stall_o = 1'b1;
    case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
      end
      StScan: begin
        scanning = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register; unmapped fields forced to zero
  // ---------------------------------------------------------------------------
  logic out_valid_q;

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pin_index_o       <= cnt_q;
      level_o           <= lvl;
      level_word_o      <= word_new;
      map_write_o       <= wr_map;
      map_target_o      <= wr_map ? rd_entry.target : '0;
      map_target_slot_o <= wr_map ? rd_entry.slot : '0;
      map_value_o       <= wr_map ? (lvl ? rd_entry.rise : rd_entry.fall) : '0;
      last_o            <= (chg_sr_q >> 1) == '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "assert_macros.svh"

  `DICM_ASSERT(a_scan_ends, (scanning && chg_sr_q == '0) |=> !in_stall_o, "scan did not finish")
  `DICM_ASSERT(a_word_matches, emit |=> (out_valid_o && level_word_o[pin_index_o] == level_o), "result word disagrees with level")
  `DICM_ASSERT_ALWAYS(a_unused_pins, (stored_q & ~PinMask) == '0, "unwatched pin level set")

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for digital_input_change_mapper_top: directed and random
// sample/load requests, register settings across idle phases, results checked in order.
// Depends on dicm_pkg and the RTL of the change mapper.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dicm_pkg::*;

  localparam int unsigned PinCount      = DefPinCount;
  localparam int unsigned ResetCycles   = 8;
  // time for a scan to finish after its last result, with margin on top
  localparam int unsigned LatencyCycles = PinCount + 4;
  localparam int unsigned HoldCycles    = 200;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned RandomPerPhase = 24;
  // index with no register behind it; writes there must be dropped
  localparam logic [CfgIdxW-1:0] CfgNone = 2'd3;

  // one request as offered on the input channel
  typedef struct {
    kind_e           kind;
    logic [PinW-1:0] pins;
    logic [PinIdxW-1:0] idx;
    logic            active;
    logic [TgtW-1:0] target;
    logic [TgtW-1:0] slot;
    logic [ValW-1:0] fall;
    logic [ValW-1:0] rise;
  } request_t;

  // one change event as seen on the result channel
  typedef struct packed {
    logic [PinIdxW-1:0] pin;
    logic               level;
    logic [PinW-1:0]    word;
    logic               map_write;
    logic [TgtW-1:0]    target;
    logic [TgtW-1:0]    slot;
    logic [ValW-1:0]    value;
    logic               last;
  } change_t;

  // Scoreboard: own copy of the masks, level word and mapping table; predicts the
  // change events of each accepted request and checks results against them in order.
  class change_scoreboard;
    logic [PinW-1:0] enable_bits;
    logic [PinW-1:0] invert_bits;
    logic [PinW-1:0] sync_bits;
    logic [PinW-1:0] levels;
    logic [PinW-1:0] pin_mask;
    map_entry_t      entries[PinW];
    change_t         due_changes[$];
    int unsigned     errors;

    function new();
      enable_bits = '0;
      invert_bits = '0;
      sync_bits   = '0;
      levels      = '0;
      errors      = 0;
      pin_mask    = (PinCount >= PinW) ? '1 : PinW'((1 << PinCount) - 1);
      foreach (entries[i]) entries[i] = '0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [PinW-1:0] data);
      case (idx)
        CfgEnable: enable_bits = data;
        CfgInvert: invert_bits = data;
        CfgSync:   sync_bits   = data;
        default: ;
      endcase
    endfunction

    function void note_request(request_t req);
      logic [PinW-1:0] qual;
      logic [PinW-1:0] changed;
      change_t         ev;
      if (req.kind == KindLoad) begin
        if (int'(req.idx) < PinCount) begin
          entries[req.idx] = '{active: req.active, target: req.target, slot: req.slot,
                               fall: req.fall, rise: req.rise};
        end
        return;
      end
      qual    = req.pins ^ invert_bits;
      changed = (qual ^ levels) & enable_bits & pin_mask;
      for (int i = 0; i < PinW; i++) begin
        if (changed[i]) begin
          levels[i]    = qual[i];
          changed[i]   = 1'b0;
          ev           = '0;
          ev.pin       = PinIdxW'(i);
          ev.level     = qual[i];
          ev.word      = levels;
          // rising writes can be held back per pin; falling ones never are
          if (entries[i].active && (!qual[i] || !sync_bits[i])) begin
            ev.map_write = 1'b1;
            ev.target    = entries[i].target;
            ev.slot      = entries[i].slot;
            ev.value     = qual[i] ? entries[i].rise : entries[i].fall;
          end
          ev.last = (changed == '0);
          due_changes.push_back(ev);
        end
      end
    endfunction

    function void compare_field(string name, logic [PinW-1:0] want_v, logic [PinW-1:0] seen_v);
      if (seen_v !== want_v) begin
        $error("%s: expected %0h, got %0h", name, want_v, seen_v);
        errors++;
      end
    endfunction

    function void check_change(change_t seen);
      change_t want;
      if (due_changes.size() == 0) begin
        $error("result for pin %0d with nothing outstanding", seen.pin);
        errors++;
        return;
      end
      want = due_changes.pop_front();
      compare_field("pin_index",       want.pin,       seen.pin);
      compare_field("level",           want.level,     seen.level);
      compare_field("level_word",      want.word,      seen.word);
      compare_field("map_write",       want.map_write, seen.map_write);
      compare_field("map_target",      want.target,    seen.target);
      compare_field("map_target_slot", want.slot,      seen.slot);
      compare_field("map_value",       want.value,     seen.value);
      compare_field("last",            want.last,      seen.last);
    endfunction

    function int unsigned outstanding();
      return due_changes.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT signals; every input known from time zero
  // ---------------------------------------------------------------------------
  logic                clk_i               = 1'b0;
  logic                rst_ni              = 1'b0;
  logic                in_valid_i          = 1'b0;
  logic                in_stall_o;
  logic                kind_i              = KindSample;
  logic [PinW-1:0]     pins_i              = '0;
  logic [PinIdxW-1:0]  entry_index_i       = '0;
  logic                entry_active_i      = 1'b0;
  logic [TgtW-1:0]     entry_target_i      = '0;
  logic [TgtW-1:0]     entry_target_slot_i = '0;
  logic [ValW-1:0]     entry_fall_value_i  = '0;
  logic [ValW-1:0]     entry_rise_value_i  = '0;
  logic                out_valid_o;
  logic                out_stall_i         = 1'b0;
  logic [PinIdxW-1:0]  pin_index_o;
  logic                level_o;
  logic [PinW-1:0]     level_word_o;
  logic                map_write_o;
  logic [TgtW-1:0]     map_target_o;
  logic [TgtW-1:0]     map_target_slot_o;
  logic [ValW-1:0]     map_value_o;
  logic                last_o;
  logic                cfg_valid_i         = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i         = '0;
  logic [PinW-1:0]     cfg_data_i          = '0;

  // idling knobs, percent of cycles; hold-off is started by the stimulus and
  // then counted down by the result side on its own
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          start_hold = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  logic [PinW-1:0] last_pins = '0;

  change_scoreboard sb;

  digital_input_change_mapper_top #(.PIN_COUNT(PinCount)) dut (.*);

  always begin
    #2ns clk_i = 1'b1;
    #2ns clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Result side: check what was taken at this edge, then pick the next stall.
  // Signals are read before any NBA update of this edge, so ordering is safe.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_change(change_t'{pin: pin_index_o, level: level_o, word: level_word_o,
                                map_write: map_write_o, target: map_target_o,
                                slot: map_target_slot_o, value: map_value_o,
                                last: last_o});
    end
    if (start_hold) begin
      hold_left  = HoldCycles;
      start_hold = 1'b0;
    end
    if (hold_left != 0) begin
      // long hold-off: the block fills up and must stall its request side
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: any handshake on any channel counts as progress
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request builders; fields a request ignores still carry random bits
  // ---------------------------------------------------------------------------
  function automatic request_t noise_request();
    request_t r;
    r.kind   = KindSample;
    r.pins   = PinW'($urandom);
    r.idx    = PinIdxW'($urandom);
    r.active = 1'($urandom);
    r.target = TgtW'($urandom);
    r.slot   = TgtW'($urandom);
    r.fall   = ValW'($urandom);
    r.rise   = ValW'($urandom);
    return r;
  endfunction

  function automatic request_t sample_req(logic [PinW-1:0] pins);
    request_t r;
    r = noise_request();
    r.pins = pins;
    last_pins = pins;
    return r;
  endfunction

  function automatic request_t load_req(logic [PinIdxW-1:0] idx, logic act,
                                        logic [TgtW-1:0] tgt, logic [TgtW-1:0] slt,
                                        logic [ValW-1:0] fv, logic [ValW-1:0] rv);
    request_t r;
    r = noise_request();
    r.kind   = KindLoad;
    r.idx    = idx;
    r.active = act;
    r.target = tgt;
    r.slot   = slt;
    r.fall   = fv;
    r.rise   = rv;
    return r;
  endfunction

  // Half of the samples close to the previous one so that scans stay varied in length;
  // the rest full random or all-ones/all-zeros; about one request in five is a table load.
  function automatic request_t random_request();
    logic [PinW-1:0] p;
    if ($urandom_range(99) < 20) begin
      return load_req(PinIdxW'($urandom), ($urandom_range(3) != 0), TgtW'($urandom),
                      TgtW'($urandom), ValW'($urandom), ValW'($urandom));
    end
    case ($urandom_range(3))
      0:       p = PinW'($urandom);
      1:       p = last_pins ^ (PinW'(1) << $urandom_range(PinW - 1));
      2:       p = last_pins ^ PinW'($urandom & $urandom);
      default: p = ($urandom_range(1) != 0) ? '1 : '0;
    endcase
    return sample_req(p);
  endfunction

  function automatic logic [PinW-1:0] pick_reg();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return PinW'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers; each is entered just after a rising edge
  // ---------------------------------------------------------------------------
  task automatic send_request(input request_t req);
    int unsigned gap;
    gap = 0;
    while (($urandom_range(99) < send_idle_pct) && (gap < 64)) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    kind_i              <= req.kind;
    pins_i              <= req.pins;
    entry_index_i       <= req.idx;
    entry_active_i      <= req.active;
    entry_target_i      <= req.target;
    entry_target_slot_i <= req.slot;
    entry_fall_value_i  <= req.fall;
    entry_rise_value_i  <= req.rise;
    in_valid_i          <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req);
  endtask

  // Valid stays high across back-to-back writes, lowered once at the end
  task automatic configure(input logic [PinW-1:0] en, input logic [PinW-1:0] inv,
                           input logic [PinW-1:0] syn, input bit poke_unused);
    logic [CfgIdxW-1:0] idx_q[$];
    logic [PinW-1:0]    data_q[$];
    if (poke_unused) begin
      idx_q.push_back(CfgNone);
      data_q.push_back(PinW'($urandom));
    end
    idx_q.push_back(CfgEnable);  data_q.push_back(en);
    idx_q.push_back(CfgInvert);  data_q.push_back(inv);
    idx_q.push_back(CfgSync);    data_q.push_back(syn);
    foreach (idx_q[k]) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx_q[k];
      cfg_data_i  <= data_q[k];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.write_reg(idx_q[k], data_q[k]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Wait for every predicted change, then let a scan with no output finish too
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (LatencyCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct);
    drain();
    configure(pick_reg(), pick_reg(), pick_reg(), 1'($urandom));
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (RandomPerPhase) send_request(random_request());
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    sb = new();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: all pins watched, no inversion, rising writes allowed
    configure('1, '0, '0, 1'b1);
    load_and_go: begin
      send_request(load_req(4'd0,  1'b1, 8'hFF, 8'h00, 16'h0000, 16'hFFFF));
      send_request(load_req(4'd15, 1'b1, 8'h00, 8'hFF, 16'hFFFF, 16'h0000));
      send_request(load_req(4'd7,  1'b0, 8'hA5, 8'h5A, 16'h1234, 16'h4321)); // no mapping
      send_request(load_req(4'd9,  1'b1, 8'h3C, 8'hC3, 16'hBEEF, 16'hCAFE));
      send_request(sample_req(16'hFFFF));  // every pin rises: longest scan
      send_request(sample_req(16'hFFFF));  // no change, no result
      send_request(sample_req(16'h0000));  // every pin falls
      send_request(sample_req(16'h8001));  // lowest and highest pin only
      send_request(sample_req(16'h0200));
    end

    // sync on every pin: rising changes carry no mapped write
    drain();
    configure('1, '0, '1, 1'b0);
    send_request(sample_req(16'hFFFF));
    send_request(sample_req(16'h0000));

    // nothing watched
    drain();
    configure('0, '1, '0, 1'b0);
    send_request(sample_req(16'h1234));

    // all pins inverted
    drain();
    configure('1, '1, '0, 1'b1);
    send_request(sample_req(16'h0000));
    send_request(sample_req(16'hFFFF));
    send_request(load_req(4'd0, 1'b0, 8'h11, 8'h22, 16'h3333, 16'h4444)); // unmap pin 0
    send_request(sample_req(16'h0001));

    drain();
    configure(16'h5555, 16'hAAAA, 16'h3333, 1'b0);
    send_request(sample_req(PinW'($urandom)));
    send_request(sample_req(PinW'($urandom)));

    // random phases: free-running, sender idling, receiver stalling, both
    run_phase(0, 0);
    run_phase(74, 0);
    run_phase(0, 74);
    run_phase(30, 30);

    // back-pressure: receiver holds off while requests keep coming; every pin
    // watched so that changes pile up behind the held result
    drain();
    configure('1, pick_reg(), pick_reg(), 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    start_hold     = 1'b1;
    repeat (18) send_request(random_request());

    drain();
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
